### hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// shared constants, codes and controller/datapath signal groups for the
// bitmap page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int PAGES      = 512;
    localparam int WORD_BITS  = 64;
    localparam int MAP_WORDS  = (PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W      = 6;
    localparam int PAGE_SHIFT = 12;
    localparam int CNT_W      = $clog2(PAGES + 1);

    localparam int FSP_W      = 52;
    localparam int AVAIL_W    = 10;
    localparam int ADDR_W     = 64;
    localparam int STATUS_W   = 2;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 4;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 72;

    localparam logic [AVAIL_W-1:0] AVAIL_RESET = AVAIL_W'(512);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_PAGE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_POOL = 2'd2;

    localparam logic REG_FREE_START = 1'b0;
    localparam logic REG_AVAILABLE  = 1'b1;

    typedef struct packed {
        logic capture;
        logic do_scan;
        logic do_free;
        logic load_out;
    } bpa_cmd_t;

    typedef struct packed {
        logic scan_done;
    } bpa_stat_t;

endpackage

### hw/rtl/bpa_regs.sv
// ----------------------------------------------------------------------------
// bpa_regs
// apb configuration registers: free start page and available page count
// ----------------------------------------------------------------------------
module bpa_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpa_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [bpa_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [bpa_pkg::FSP_W-1:0]       free_start_page,
    output logic [bpa_pkg::AVAIL_W-1:0]     available_pages
);
    import bpa_pkg::*;

    logic [FSP_W-1:0]   fsp_reg;
    logic [AVAIL_W-1:0] avail_reg;
    logic               wr_en;
    logic               sel;

    assign pready = 1'b1;
    assign sel    = paddr[3];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsp_reg   <= '0;
            avail_reg <= AVAIL_RESET;
        end else if (wr_en) begin
            unique case (sel)
                REG_FREE_START: fsp_reg   <= pwdata[FSP_W-1:0];
                REG_AVAILABLE:  avail_reg <= pwdata[AVAIL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_FREE_START: prdata = CFG_DATA_W'(fsp_reg);
            REG_AVAILABLE:  prdata = CFG_DATA_W'(avail_reg);
            default:        prdata = '0;
        endcase
    end

    assign free_start_page = fsp_reg;
    assign available_pages = avail_reg;

endmodule

### hw/rtl/bpa_datapath.sv
// ----------------------------------------------------------------------------
// bpa_datapath
// in-use map, word scanner with reserved-page mask, address arithmetic and
// result/output registers
// ----------------------------------------------------------------------------
module bpa_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bpa_pkg::bpa_cmd_t              cmd,
    output bpa_pkg::bpa_stat_t             stat,
    input  logic [bpa_pkg::ADDR_W-1:0]     in_addr,
    input  logic [bpa_pkg::FSP_W-1:0]      free_start_page,
    input  logic [bpa_pkg::AVAIL_W-1:0]    available_pages,
    output logic [bpa_pkg::ADDR_W-1:0]     out_addr,
    output logic [bpa_pkg::STATUS_W-1:0]   out_status
);
    import bpa_pkg::*;

    logic [WORD_BITS-1:0]  map_reg [MAP_WORDS];
    logic [WORD_W-1:0]     word_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [ADDR_W-1:0]     res_addr_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [ADDR_W-1:0]     out_addr_reg;
    logic [STATUS_W-1:0]   out_status_reg;

    logic [CNT_W-1:0]      reserved;
    logic [WORD_BITS-1:0]  taken_mask;
    logic [WORD_BITS-1:0]  free_vec;
    logic                  found;
    logic [BIT_W-1:0]      enc;
    logic [FSP_W-1:0]      first_page;
    logic [FSP_W-1:0]      grant_page;
    logic [FSP_W-1:0]      rel_page;
    logic                  in_pool;
    logic [WORD_W-1:0]     free_word;
    logic [BIT_W-1:0]      free_bit;

    // pages below the reserved count or beyond the pool count as taken
    always_comb begin
        if (int'(available_pages) >= PAGES) begin
            reserved = '0;
        end else begin
            reserved = CNT_W'(PAGES - int'(available_pages));
        end
        for (int b = 0; b < WORD_BITS; b++) begin
            taken_mask[b] = ((int'(word_reg) * WORD_BITS + b) < int'(reserved))
                         || ((int'(word_reg) * WORD_BITS + b) >= PAGES);
        end
        free_vec = ~(map_reg[word_reg] | taken_mask);
        found    = |free_vec;
        enc      = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (free_vec[i]) begin
                enc = BIT_W'(i);
            end
        end
    end

    assign first_page = free_start_page + FSP_W'(available_pages) - FSP_W'(PAGES);
    assign grant_page = first_page + FSP_W'({word_reg, enc});
    assign rel_page   = addr_reg[ADDR_W-1:PAGE_SHIFT] - first_page;
    assign in_pool    = rel_page < FSP_W'(PAGES);
    assign free_word  = WORD_W'(rel_page >> BIT_W);
    assign free_bit   = rel_page[BIT_W-1:0];

    assign stat.scan_done = found || (word_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < MAP_WORDS; w++) begin
                map_reg[w] <= '0;
            end
        end else if (cmd.do_scan && found) begin
            map_reg[word_reg][enc] <= 1'b1;
        end else if (cmd.do_free && in_pool) begin
            map_reg[free_word][free_bit] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            addr_reg <= in_addr;
            word_reg <= WORD_W'(MAP_WORDS - 1);
        end else if (cmd.do_scan && !found && word_reg != '0) begin
            word_reg <= word_reg - 1'b1;
        end
        if (cmd.do_scan) begin
            if (found) begin
                res_addr_reg   <= {grant_page, {PAGE_SHIFT{1'b0}}};
                res_status_reg <= ST_DONE;
            end else begin
                res_addr_reg   <= '0;
                res_status_reg <= ST_NO_PAGE;
            end
        end
        if (cmd.do_free) begin
            res_addr_reg   <= '0;
            res_status_reg <= in_pool ? ST_DONE : ST_OUT_OF_POOL;
        end
        if (cmd.load_out) begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_addr   = out_addr_reg;
    assign out_status = out_status_reg;

`ifndef SYNTH
    a_scan_ends_at_last_word: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_scan && word_reg == '0 |-> stat.scan_done)
        else $error("scan ran past the lowest map word");
    a_grant_marks_page: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_scan && found |=> map_reg[$past(word_reg)][$past(enc)])
        else $error("granted page not marked in use");
    a_status_code_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> out_status_reg != 2'd3)
        else $error("undefined status code loaded");
`endif

endmodule

### hw/rtl/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// request sequencer: accept, scan or free, then hand the result to the
// output register
// ----------------------------------------------------------------------------
module bpa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                in_cmd,
    output logic                m_tvalid,
    input  logic                m_tready,
    output bpa_pkg::bpa_cmd_t   cmd,
    input  bpa_pkg::bpa_stat_t  stat
);
    import bpa_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        FREE,
        DONE
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd.capture  = (state_reg == IDLE) && s_tvalid;
        cmd.do_scan  = (state_reg == SCAN);
        cmd.do_free  = (state_reg == FREE);
        cmd.load_out = (state_reg == DONE) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= (in_cmd == CMD_FREE) ? FREE : SCAN;
                    end
                end
                SCAN: begin
                    if (stat.scan_done) begin
                        state_reg <= DONE;
                    end
                end
                FREE: begin
                    state_reg <= DONE;
                end
                DONE: begin
                    if (out_free) begin
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_result_presented: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_tvalid_reg)
        else $error("loaded result not presented");
    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> !s_tready)
        else $error("request accepted while previous one in progress");
`endif

endmodule

### hw/rtl/bitmap_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit
// bitmap page allocator: grants the highest free page of the pool or frees
// the page at a given address, with an apb configuration port
// ----------------------------------------------------------------------------
//  channel  | ports                 | contents
//  ---------+-----------------------+---------------------------------------
//  s_       | tvalid tready tdata   | tuser = command, tdata = page_address
//           | tuser                 |
//  m_       | tvalid tready tdata   | granted_address, status
//  apb      | psel penable pwrite.. | 0x0 free_start_page, 0x8 available_pages
//
//  allocate: the accept step, then one map word scanned per cycle from the top
//  word down until a free page or the lowest word is met, then the result is staged
//  free: capture, then address subtract and clear, then stage the result
//  reset clears the whole in-use map at once; configuration registers return to defaults
//  a result waiting on m_ holds back only the staging step of the next request
// ----------------------------------------------------------------------------
module bitmap_page_allocator_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [63:0] page_address
    input  logic [bpa_pkg::S_DATA_W-1:0]    s_tdata,
    // [0] command
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [63:0] granted_address, [65:64] status, [71:66] zero
    output logic [bpa_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpa_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [bpa_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import bpa_pkg::*;

    bpa_cmd_t              cmd;
    bpa_stat_t             stat;
    logic [FSP_W-1:0]      free_start_page;
    logic [AVAIL_W-1:0]    available_pages;
    logic [ADDR_W-1:0]     out_addr;
    logic [STATUS_W-1:0]   out_status;

    bpa_regs u_regs (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .free_start_page (free_start_page),
        .available_pages (available_pages)
    );

    bpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_cmd   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bpa_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .in_addr         (s_tdata),
        .free_start_page (free_start_page),
        .available_pages (available_pages),
        .out_addr        (out_addr),
        .out_status      (out_status)
    );

    assign m_tdata = {{(M_DATA_W - ADDR_W - STATUS_W){1'b0}}, out_status, out_addr};

endmodule
